### rtl/ted_pkg.sv
// Shared types and constants for the text escape decoder.
// No dependencies; used by ted_core, ted_out_buf and text_escape_decoder.
`default_nettype none

package ted_pkg;

  // Width of the byte position counter; it saturates at all ones
  localparam int unsigned POS_BITS = 16;
  // Width of the reported stop position
  localparam int unsigned STOP_BITS = 16;
  // Number of separator slots
  localparam int unsigned SEP_SLOTS = 4;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEP_COUNT = 1'b0,
    CFG_SEP_CHARS = 1'b1
  } cfg_index_t;

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_LO_N      = 8'h6E;
  localparam logic [7:0] CH_UP_N      = 8'h4E;
  localparam logic [7:0] CH_LO_T      = 8'h74;
  localparam logic [7:0] CH_UP_T      = 8'h54;
  localparam logic [7:0] CH_LO_R      = 8'h72;
  localparam logic [7:0] CH_UP_R      = 8'h52;
  localparam logic [7:0] CH_LO_B      = 8'h62;
  localparam logic [7:0] CH_UP_B      = 8'h42;
  localparam logic [7:0] CH_LO_F      = 8'h66;
  localparam logic [7:0] CH_UP_F      = 8'h46;

  // One result item
  typedef struct packed {
    logic [7:0]           char_out;
    logic                 has_char;
    logic                 end_of_value;
    logic                 hit_separator;
    logic [STOP_BITS-1:0] stop_position;
  } result_t;

  // Map the byte after a backslash to its decoded value
  function automatic logic [7:0] decode_escaped(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_LO_N, CH_UP_N: r = CH_LF;
      CH_LO_T, CH_UP_T: r = CH_TAB;
      CH_LO_R, CH_UP_R: r = CH_CR;
      CH_LO_B, CH_UP_B: r = CH_BS;
      CH_LO_F, CH_UP_F: r = CH_FF;
      CH_SEMICOLON, CH_COMMA, CH_DQUOTE, CH_BACKSLASH: r = c;
      default: r = CH_SPACE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/ted_core.sv
// Decode core: configuration registers, per-value state and result logic.
// Depends on ted_pkg.
`default_nettype none

module ted_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [31:0]                cfg_data,
  input  wire logic                       take,
  input  wire logic [7:0]                 char_in,
  input  wire logic                       is_final,
  output ted_pkg::result_t                result
);

  logic [2:0]                      sep_count;
  logic [8*ted_pkg::SEP_SLOTS-1:0] sep_chars;
  logic                            in_escape;
  logic                            stopped;
  logic [ted_pkg::POS_BITS-1:0]    byte_position;

  logic                            in_escape_next;
  logic                            stopped_next;
  logic [ted_pkg::POS_BITS-1:0]    byte_position_next;
  logic [ted_pkg::SEP_SLOTS-1:0]   sep_hit;
  logic                            is_sep;
  logic [ted_pkg::POS_BITS+ted_pkg::STOP_BITS-1:0] pos_ext;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_count <= '0;
      sep_chars <= '0;
    end else if (cfg_we) begin
      case (ted_pkg::cfg_index_t'(cfg_index))
        ted_pkg::CFG_SEP_COUNT: sep_count <= cfg_data[2:0];
        ted_pkg::CFG_SEP_CHARS: sep_chars <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compare against every active separator slot; counts above four enable all
  always_comb begin
    for (int i = 0; i < ted_pkg::SEP_SLOTS; i++) begin
      sep_hit[i] = (sep_count > 3'(i)) && (sep_chars[8*i +: 8] == char_in);
    end
    is_sep = |sep_hit;
  end

  // Decode one byte and work out the state after it
  always_comb begin
    in_escape_next     = in_escape;
    stopped_next       = stopped;
    byte_position_next = byte_position;
    result.char_out    = '0;
    result.has_char    = 1'b0;
    if (!stopped) begin
      if (in_escape) begin
        result.char_out = ted_pkg::decode_escaped(char_in);
        result.has_char = 1'b1;
        in_escape_next  = 1'b0;
      end else if (char_in == ted_pkg::CH_BACKSLASH) begin
        in_escape_next = 1'b1;
      end else if (is_sep) begin
        stopped_next = 1'b1;
      end else begin
        result.char_out = char_in;
        result.has_char = 1'b1;
      end
      if (!stopped_next && (byte_position != '1)) begin
        byte_position_next = byte_position + 1'b1;
      end
    end
    pos_ext              = {{ted_pkg::STOP_BITS{1'b0}}, byte_position_next};
    result.end_of_value  = is_final;
    result.hit_separator = stopped_next;
    result.stop_position = pos_ext[ted_pkg::STOP_BITS-1:0];
  end

  // Advance state on each taken item; clear it at the end of a value
  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape     <= 1'b0;
      stopped       <= 1'b0;
      byte_position <= '0;
    end else if (take) begin
      if (is_final) begin
        in_escape     <= 1'b0;
        stopped       <= 1'b0;
        byte_position <= '0;
      end else begin
        in_escape     <= in_escape_next;
        stopped       <= stopped_next;
        byte_position <= byte_position_next;
      end
    end
  end

  // A value always starts from clean state after its last byte
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    take && is_final |=> !stopped && !in_escape && byte_position == '0)
    else $error("state not cleared after final byte");

  // Once stopped, position holds until the value ends
  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    take && stopped && !is_final |=> stopped && $stable(byte_position))
    else $error("stop position moved after separator");

  // While stopped, no new byte is produced
  a_stop_no_char: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !result.has_char)
    else $error("byte produced after separator");

  // An escape start yields no byte
  a_escape_start: assert property (@(posedge clk) disable iff (rst)
    take && !stopped && !in_escape && char_in == ted_pkg::CH_BACKSLASH
      |-> !result.has_char)
    else $error("backslash produced a byte");

endmodule

`default_nettype wire

### rtl/ted_out_buf.sv
// Result register with a skid stage, so input and output stall apart.
// Depends on ted_pkg.
`default_nettype none

module ted_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  ted_pkg::result_t       in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ted_pkg::result_t       out_data
);

  logic             main_valid;
  logic             skid_valid;
  ted_pkg::result_t main_data;
  ted_pkg::result_t skid_data;
  logic             push;
  logic             main_free;

  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready;
  assign main_free = !main_valid || out_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Track occupancy of result and skid stages
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload: skid drains first, else new item lands in result stage
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (push) begin
      skid_data <= in_data;
    end
  end

  // Skid stage is only used behind a full result stage
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds item while result stage empty");

  // A stalled result with a new item pushed fills the skid stage
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    main_valid && !out_ready && push |=> skid_valid)
    else $error("item lost on stall");

  // A drained skid moves into the result stage
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> main_valid && !skid_valid)
    else $error("skid not drained");

endmodule

`default_nettype wire

### rtl/text_escape_decoder.sv
// Top level of the backslash escape decoder: streaming ports and config port.
// Depends on ted_pkg, ted_core and ted_out_buf.
//
//  channel  | signals                                 | item
//  ---------+-----------------------------------------+---------------------------
//  input    | s_tvalid s_tready s_tdata s_tlast       | one text byte, last mark
//  output   | m_tvalid m_tready m_tdata m_tuser m_tlast| one decoded result
//  config   | cfg_we cfg_index cfg_data               | separator count / chars
//
// One item per cycle while the output is not stalled; each accepted byte's result
// is registered in the result stage, or in the skid stage behind a held result.
// The two-entry result buffer drops s_tready only while its skid stage is full.
// rst (synchronous) clears the escape, stop and position state and the config.
`default_nettype none

module text_escape_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_in
  input  wire logic        s_tlast,   // is_final
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] char_out, [23:8] stop_position
  output logic [1:0]       m_tuser,   // [0] has_char, [1] hit_separator
  output logic             m_tlast    // end_of_value
);

  ted_pkg::result_t res;
  ted_pkg::result_t res_out;
  logic             take;

  assign take = s_tvalid && s_tready;

  // Decode each accepted byte
  ted_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .take     (take),
    .char_in  (s_tdata),
    .is_final (s_tlast),
    .result   (res)
  );

  // Hold results until taken
  ted_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (res),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (res_out)
  );

  assign m_tdata = {res_out.stop_position, res_out.char_out};
  assign m_tuser = {res_out.hit_separator, res_out.has_char};
  assign m_tlast = res_out.end_of_value;

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for text_escape_decoder: directed and random byte streams.
// Depends on ted_pkg and the RTL of text_escape_decoder. A built-in decode predictor
// scores every output item in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock, reset and block inputs, all known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = ted_pkg::CFG_SEP_COUNT;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] char_in
  logic        s_tlast = 1'b0;  // is_final
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [7:0] char_out, [23:8] stop_position
  logic [1:0]  m_tuser;         // [0] has_char, [1] hit_separator
  logic        m_tlast;         // end_of_value

  text_escape_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the separator registers and the decode state
  logic [2:0]                   sep_count_cfg = '0;
  logic [31:0]                  sep_chars_cfg = '0;
  logic                         dec_in_escape = 1'b0;
  logic                         dec_stopped = 1'b0;
  logic [ted_pkg::POS_BITS-1:0] dec_position = '0;

  // Expected output items, oldest first
  ted_pkg::result_t expected_q[$];

  // Idling and stall controls
  int unsigned tx_idle_pct = 33;
  int unsigned rx_idle_pct = 33;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Run statistics
  int unsigned mismatch_count = 0;
  int unsigned item_count = 0;
  int unsigned value_count = 0;
  int unsigned result_count = 0;
  int unsigned stop_count = 0;
  int unsigned escape_count = 0;

  // Byte after a backslash: letters fold case, a few punctuation marks pass, rest is space
  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if ((c & 8'hDF) >= 8'h41 && (c & 8'hDF) <= 8'h5A) begin
      if (folded == ted_pkg::CH_LO_N) return ted_pkg::CH_LF;
      if (folded == ted_pkg::CH_LO_T) return ted_pkg::CH_TAB;
      if (folded == ted_pkg::CH_LO_R) return ted_pkg::CH_CR;
      if (folded == ted_pkg::CH_LO_B) return ted_pkg::CH_BS;
      if (folded == ted_pkg::CH_LO_F) return ted_pkg::CH_FF;
      return ted_pkg::CH_SPACE;
    end
    if (c == ted_pkg::CH_SEMICOLON || c == ted_pkg::CH_COMMA ||
        c == ted_pkg::CH_DQUOTE || c == ted_pkg::CH_BACKSLASH) return c;
    return ted_pkg::CH_SPACE;
  endfunction

  // Match against the active separator slots; counts above the slot total clamp
  function automatic bit is_stop_char(input logic [7:0] c);
    int unsigned active;
    active = (sep_count_cfg > ted_pkg::SEP_SLOTS) ? ted_pkg::SEP_SLOTS : sep_count_cfg;
    for (int unsigned i = 0; i < active; i++)
      if (sep_chars_cfg[8*i +: 8] == c) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the decode state by one byte and return the output item it gives
  function automatic ted_pkg::result_t decode_byte(input logic [7:0] c, input logic fin);
    ted_pkg::result_t r;
    r = '0;
    if (!dec_stopped) begin
      if (dec_in_escape) begin
        r.char_out = unescape(c);
        r.has_char = 1'b1;
        dec_in_escape = 1'b0;
        escape_count++;
      end else if (c == ted_pkg::CH_BACKSLASH) begin
        dec_in_escape = 1'b1;
      end else if (is_stop_char(c)) begin
        dec_stopped = 1'b1;
        stop_count++;
      end else begin
        r.char_out = c;
        r.has_char = 1'b1;
      end
      // saturate, never wrap
      if (!dec_stopped && dec_position != '1) dec_position = dec_position + 1'b1;
    end
    r.end_of_value  = fin;
    r.hit_separator = dec_stopped;
    r.stop_position = ted_pkg::STOP_BITS'(dec_position);
    if (fin) begin
      dec_in_escape = 1'b0;
      dec_stopped   = 1'b0;
      dec_position  = '0;
    end
    return r;
  endfunction

  // Offer one byte, hold it until accepted, then record its expected item
  task automatic send_char(input logic [7:0] c, input logic last);
    ted_pkg::result_t want;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    want = decode_byte(c, last);
    expected_q.push_back(want);
    item_count++;
    if (last) value_count++;
  endtask

  // Drop valid and hold until every expected item has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic configure(input logic [2:0] count, input logic [31:0] chars);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= ted_pkg::CFG_SEP_COUNT;
    cfg_data  <= {29'd0, count};
    @(posedge clk);
    sep_count_cfg = count;
    cfg_index <= ted_pkg::CFG_SEP_CHARS;
    cfg_data  <= chars;
    @(posedge clk);
    sep_chars_cfg = chars;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] escape_target(input int unsigned idx);
    case (idx)
      0: return ted_pkg::CH_LO_N;
      1: return ted_pkg::CH_UP_N;
      2: return ted_pkg::CH_LO_T;
      3: return ted_pkg::CH_UP_T;
      4: return ted_pkg::CH_LO_R;
      5: return ted_pkg::CH_UP_R;
      6: return ted_pkg::CH_LO_B;
      7: return ted_pkg::CH_UP_B;
      8: return ted_pkg::CH_LO_F;
      9: return ted_pkg::CH_UP_F;
      10: return ted_pkg::CH_SEMICOLON;
      11: return ted_pkg::CH_COMMA;
      default: return ted_pkg::CH_DQUOTE;
    endcase
  endfunction

  // Byte mix: backslashes, escape letters, live separators and plain noise
  function automatic logic [7:0] pick_char();
    int unsigned sel;
    logic [7:0]  slot_char;
    sel = $urandom_range(99);
    if (sel < 15) return ted_pkg::CH_BACKSLASH;
    if (sel < 35) return escape_target($urandom_range(12));
    if (sel < 45 && sep_count_cfg != 0) begin
      slot_char = sep_chars_cfg[8*$urandom_range(ted_pkg::SEP_SLOTS - 1) +: 8];
      if (slot_char != 8'h00) return slot_char;
    end
    return 8'($urandom_range(255, 1));
  endfunction

  // Separator set with mostly printable bytes, now and then any byte
  function automatic logic [31:0] pick_sep_chars();
    logic [31:0] v;
    for (int unsigned i = 0; i < ted_pkg::SEP_SLOTS; i++)
      v[8*i +: 8] = ($urandom_range(3) != 0) ? 8'($urandom_range(126, 33))
                                             : 8'($urandom_range(255, 0));
    return v;
  endfunction

  // One value: usually short, sometimes long
  task automatic send_random_value(input int unsigned max_len);
    int unsigned len;
    len = ($urandom_range(9) == 0) ? $urandom_range(max_len, 1) : $urandom_range(16, 1);
    for (int unsigned i = 0; i < len; i++) send_char(pick_char(), i == len - 1);
  endtask

  // Plain bytes at both extremes, most escapes, trailing lone backslash; reset config
  task automatic test_escapes();
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(ted_pkg::CH_LO_N, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(ted_pkg::CH_UP_T, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(ted_pkg::CH_LO_R, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(ted_pkg::CH_UP_B, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(ted_pkg::CH_LO_F, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(ted_pkg::CH_SEMICOLON, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(ted_pkg::CH_DQUOTE, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(ted_pkg::CH_BACKSLASH, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0); send_char(8'h78, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b1);
  endtask

  // Escaped separator, backslash in a slot, stop mid-value and on the final byte
  task automatic test_separators();
    configure(3'd4, {8'hFF, ted_pkg::CH_COMMA, 8'h3A, ted_pkg::CH_BACKSLASH});
    send_char(8'h61, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0);
    send_char(8'h3A, 1'b0);
    send_char(8'h3A, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0);
    send_char(8'h63, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  // Random values under one separator setting and idling mix
  task automatic run_phase(input logic [2:0] count, input logic [31:0] chars,
                           input int unsigned rx_pct, input int unsigned tx_pct,
                           input int unsigned n_items);
    int unsigned start;
    configure(count, chars);
    rx_idle_pct = rx_pct;
    tx_idle_pct = tx_pct;
    start = item_count;
    while (item_count - start < n_items) send_random_value(40);
  endtask

  task automatic test_random_traffic();
    run_phase(3'd0, pick_sep_chars(), 33, 33, 300);
    run_phase(3'd4, 32'hFFFF_FFFF, 33, 33, 250);
    run_phase(3'd4, 32'h0000_0000, 33, 33, 200);
    // long stretch with no idling on either side
    run_phase(3'($urandom_range(3, 1)), pick_sep_chars(), 0, 0, 300);
    run_phase(3'($urandom_range(4, 1)), pick_sep_chars(), 33, 33, 300);
    run_phase(3'd4, {ted_pkg::CH_DQUOTE, ted_pkg::CH_SEMICOLON, ted_pkg::CH_COMMA, 8'h3A},
              33, 33, 300);
  endtask

  // Output held off while input keeps coming; input paused mid-value until drained
  task automatic test_backpressure();
    int unsigned start;
    configure(3'd2, {16'h0000, ted_pkg::CH_SEMICOLON, 8'h3A});
    rx_idle_pct = 33;
    tx_idle_pct = 0;
    hold_req = 1'b1;
    start = item_count;
    while (item_count - start < 60) send_random_value(16);
    send_char(8'h41, 1'b0);
    send_char(ted_pkg::CH_BACKSLASH, 1'b0);
    wait_drained();
    send_char(ted_pkg::CH_UP_N, 1'b0);
    send_char(8'h42, 1'b1);
    tx_idle_pct = 33;
    start = item_count;
    while (item_count - start < 80) send_random_value(24);
  endtask

  // Output-side readiness: random idling or a counted hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Score each accepted output item against the oldest expectation
  always @(posedge clk) begin
    ted_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected output item, expected none, got tdata 0x%0h", $time,
                 m_tdata);
      end else begin
        want = expected_q.pop_front();
        check_field("char_out", 32'(want.char_out), 32'(m_tdata[7:0]));
        check_field("stop_position", 32'(want.stop_position), 32'(m_tdata[23:8]));
        check_field("has_char", 32'(want.has_char), 32'(m_tuser[0]));
        check_field("hit_separator", 32'(want.hit_separator), 32'(m_tuser[1]));
        check_field("end_of_value", 32'(want.end_of_value), 32'(m_tlast));
        result_count++;
      end
    end
  end

  // Sequence the tests, then drain and report
  initial begin
    int unsigned drain_cycles;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_escapes();
    test_separators();
    test_random_traffic();
    test_backpressure();
    s_tvalid <= 1'b0;
    drain_cycles = 0;
    while (expected_q.size() != 0 && drain_cycles < 10000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0)
      $display("%0t ns: %0d output items never arrived", $time, expected_q.size());
    $display("Covered %0d input bytes in %0d values; %0d output items checked.",
             item_count, value_count, result_count);
    $display("Decoded %0d escapes and %0d separator stops under stalls and hold-offs.",
             escape_count, stop_count);
    if (expected_q.size() == 0 && mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("%0t ns: timeout with %0d output items outstanding", $time, expected_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/ted_pkg.sv
rtl/ted_core.sv
rtl/ted_out_buf.sv
rtl/text_escape_decoder.sv
test/testbench.sv
